FILE: sv/esf_pkg.sv
// Shared types, constants and microcode encodings for the encoder speed filter.
package esf_pkg;

	localparam int MOTORS    = 2;
	localparam int CH_W      = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int CNT_W     = 32;
	localparam int EL_W      = 16;
	localparam int SCALE_W   = 24;
	localparam int COEFF_W   = 16;
	localparam int RPM_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Counts per second: |delta| * 1e6 fits in 51 bits, so does the quotient.
	localparam int US_W      = 20;
	localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);
	localparam int DIV_STEPS = 51;
	localparam int LOOP_W    = $clog2(DIV_STEPS);
	localparam int CPS_W     = 40;

	// Shared multiplier: 34-bit signed by 25-bit signed.
	localparam int MUL_X_W   = 34;
	localparam int MUL_Y_W   = 25;
	localparam int MUL_P_W   = MUL_X_W + MUL_Y_W;
	localparam int PP_SPLIT  = CPS_W / 2;
	localparam int PP_W      = PP_SPLIT + SCALE_W;
	localparam int ACC_W     = 64;

	localparam int PC_W      = 4;

	localparam logic [SCALE_W-1:0] RPM_SCALE_RST      = SCALE_W'(1630567);
	localparam logic [COEFF_W-1:0] FEEDBACK_COEFF_RST = COEFF_W'(55968);
	localparam logic [COEFF_W-1:0] INPUT_COEFF_RST    = COEFF_W'(4771);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RPM_SCALE      = 2'd0,
		REG_FEEDBACK_COEFF = 2'd1,
		REG_INPUT_COEFF    = 2'd2
	} cfg_reg_e_t;

	typedef struct packed {
		logic                    motor_index;
		logic signed [CNT_W-1:0] enc_count;
		logic [EL_W-1:0]         elapsed_us;
	} sample_t;

	typedef struct packed {
		logic                    motor_id;
		logic signed [RPM_W-1:0] raw_rpm;
		logic signed [RPM_W-1:0] smooth_rpm;
		logic                    saturated;
		logic                    time_error;
	} result_t;

	typedef struct packed {
		logic [SCALE_W-1:0] rpm_scale;
		logic [COEFF_W-1:0] feedback_coeff;
		logic [COEFF_W-1:0] input_coeff;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DELTA,
		OP_MULK,
		OP_DIV,
		OP_PP_HI,
		OP_PP_LO,
		OP_RAW_CLIP,
		OP_RAW_ZERO,
		OP_RAW_SAT,
		OP_FB,
		OP_IN,
		OP_FILT
	} esf_op_t;

	typedef enum logic [2:0] {
		J_NONE,
		J_ALWAYS,
		J_NO_ITEM,
		J_TERR,
		J_LOOP,
		J_ZERO,
		J_BIG,
		J_OUT_BUSY
	} esf_cond_t;

	typedef struct packed {
		esf_op_t         op;
		esf_cond_t       cond;
		logic [PC_W-1:0] target;
		logic            loop_set;
	} ucode_word_t;

	typedef struct packed {
		esf_op_t op;
	} esf_ctrl_t;

	typedef struct packed {
		logic terr;
		logic cps_zero;
		logic cps_big;
		logic out_busy;
	} esf_status_t;

endpackage

FILE: sv/esf_seq.sv
// Microcode sequencer: program ROM, step counter, loop counter and jump logic.
module esf_seq import esf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  esf_status_t status,
	output esf_ctrl_t   ctrl,
	output logic        idle
);

	localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
	localparam logic [PC_W-1:0] PC_DELTA = PC_W'(1);
	localparam logic [PC_W-1:0] PC_MULK  = PC_W'(2);
	localparam logic [PC_W-1:0] PC_DIV   = PC_W'(3);
	localparam logic [PC_W-1:0] PC_CHK   = PC_W'(4);
	localparam logic [PC_W-1:0] PC_PPHI  = PC_W'(5);
	localparam logic [PC_W-1:0] PC_PPLO  = PC_W'(6);
	localparam logic [PC_W-1:0] PC_CLIP  = PC_W'(7);
	localparam logic [PC_W-1:0] PC_ZERO  = PC_W'(8);
	localparam logic [PC_W-1:0] PC_SAT   = PC_W'(9);
	localparam logic [PC_W-1:0] PC_FB    = PC_W'(10);
	localparam logic [PC_W-1:0] PC_IN    = PC_W'(11);
	localparam logic [PC_W-1:0] PC_WAIT  = PC_W'(12);
	localparam logic [PC_W-1:0] PC_FILT  = PC_W'(13);

	function automatic ucode_word_t rom_word(input logic [PC_W-1:0] pc);
		ucode_word_t w;
		w = '{op: OP_NOP, cond: J_ALWAYS, target: PC_IDLE, loop_set: 1'b0};
		unique case (pc)
			PC_IDLE:  w = '{op: OP_LOAD,     cond: J_NO_ITEM,  target: PC_IDLE, loop_set: 1'b0};
			PC_DELTA: w = '{op: OP_DELTA,    cond: J_NONE,     target: PC_IDLE, loop_set: 1'b0};
			PC_MULK:  w = '{op: OP_MULK,     cond: J_TERR,     target: PC_ZERO, loop_set: 1'b1};
			PC_DIV:   w = '{op: OP_DIV,      cond: J_LOOP,     target: PC_DIV,  loop_set: 1'b0};
			PC_CHK:   w = '{op: OP_NOP,      cond: J_ZERO,     target: PC_ZERO, loop_set: 1'b0};
			PC_PPHI:  w = '{op: OP_PP_HI,    cond: J_BIG,      target: PC_SAT,  loop_set: 1'b0};
			PC_PPLO:  w = '{op: OP_PP_LO,    cond: J_NONE,     target: PC_IDLE, loop_set: 1'b0};
			PC_CLIP:  w = '{op: OP_RAW_CLIP, cond: J_ALWAYS,   target: PC_FB,   loop_set: 1'b0};
			PC_ZERO:  w = '{op: OP_RAW_ZERO, cond: J_ALWAYS,   target: PC_FB,   loop_set: 1'b0};
			PC_SAT:   w = '{op: OP_RAW_SAT,  cond: J_NONE,     target: PC_IDLE, loop_set: 1'b0};
			PC_FB:    w = '{op: OP_FB,       cond: J_NONE,     target: PC_IDLE, loop_set: 1'b0};
			PC_IN:    w = '{op: OP_IN,       cond: J_NONE,     target: PC_IDLE, loop_set: 1'b0};
			PC_WAIT:  w = '{op: OP_NOP,      cond: J_OUT_BUSY, target: PC_WAIT, loop_set: 1'b0};
			PC_FILT:  w = '{op: OP_FILT,     cond: J_ALWAYS,   target: PC_IDLE, loop_set: 1'b0};
			default:  w = '{op: OP_NOP,      cond: J_ALWAYS,   target: PC_IDLE, loop_set: 1'b0};
		endcase
		return w;
	endfunction

	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   pc_d;
	logic [LOOP_W-1:0] loop_q;
	logic [LOOP_W-1:0] loop_d;
	ucode_word_t       word;
	logic              taken;
	logic              hold;

	assign word = rom_word(pc_q);

	always_comb begin
		case (word.cond)
			J_NONE:     taken = 1'b0;
			J_ALWAYS:   taken = 1'b1;
			J_NO_ITEM:  taken = !sample_valid;
			J_TERR:     taken = status.terr;
			J_LOOP:     taken = (loop_q != '0);
			J_ZERO:     taken = status.cps_zero;
			J_BIG:      taken = status.cps_big;
			J_OUT_BUSY: taken = status.out_busy;
			default:    taken = 1'b0;
		endcase
	end

	// Next step and loop count.
	always_comb begin
		pc_d = taken ? word.target : pc_q + PC_W'(1);
		loop_d = loop_q;
		if (word.loop_set) begin
			loop_d = LOOP_W'(DIV_STEPS - 1);
		end else if (word.cond == J_LOOP && loop_q != '0) begin
			loop_d = loop_q - LOOP_W'(1);
		end
	end

	// Wait steps suppress their operation while they spin.
	always_comb begin
		hold = taken && (word.cond == J_NO_ITEM || word.cond == J_OUT_BUSY);
		ctrl.op = hold ? OP_NOP : word.op;
		idle = (pc_q == PC_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_IDLE;
			loop_q <= '0;
		end else begin
			pc_q   <= pc_d;
			loop_q <= loop_d;
		end
	end

endmodule

FILE: sv/esf_dp.sv
// Datapath: per-motor state, shared multiplier, restoring divider and result register.
module esf_dp import esf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  esf_ctrl_t   ctrl,
	input  sample_t     sample,
	input  cfg_t        cfg,
	input  logic        result_stall,
	output esf_status_t status,
	output result_t     result,
	output logic        result_valid
);

	logic [CNT_W-1:0] prior_count_q [MOTORS];
	logic [RPM_W-1:0] prior_rpm_q   [MOTORS];
	logic [RPM_W-1:0] smoothed_q    [MOTORS];

	logic                 idx_q;
	logic [CH_W-1:0]      ch_q;
	logic [CH_W-1:0]      ch_in;
	logic [CNT_W-1:0]     count_q;
	logic [EL_W-1:0]      el_q;
	logic                 terr_q;
	logic                 sat_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     mag_q;
	logic [DIV_STEPS-1:0] div_q;
	logic [EL_W-1:0]      rem_q;
	logic [ACC_W-1:0]     acc_q;
	logic [RPM_W-1:0]     raw_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic [CNT_W-1:0]          delta;
	logic [EL_W:0]             partial;
	logic [EL_W:0]             diff;
	logic                      ge;
	logic [EL_W-1:0]           rem_d;
	logic signed [RPM_W:0]     rpm_sum;
	logic signed [MUL_X_W-1:0] mul_x;
	logic signed [MUL_Y_W-1:0] mul_y;
	logic signed [MUL_P_W-1:0] prod;
	logic [ACC_W-9:0]          prod_q8;
	logic [RPM_W-1:0]          raw_clip;
	logic                      raw_over;
	logic                      filt_ok;
	logic [RPM_W-1:0]          filt;

	assign ch_in = (MOTORS > 1) ? CH_W'(sample.motor_index) : '0;
	assign delta = count_q - prior_count_q[ch_q];

	// One restoring division step.
	assign partial = {rem_q, div_q[DIV_STEPS-1]};
	assign diff    = partial - {1'b0, el_q};
	assign ge      = (partial >= {1'b0, el_q});
	assign rem_d   = ge ? diff[EL_W-1:0] : partial[EL_W-1:0];

	assign rpm_sum = $signed({raw_q[RPM_W-1], raw_q})
		+ $signed({prior_rpm_q[ch_q][RPM_W-1], prior_rpm_q[ch_q]});

	// Operand select for the shared multiplier.
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (ctrl.op)
			OP_MULK: begin
				mul_x = $signed({2'b00, mag_q});
				mul_y = $signed({5'b0, US_PER_S});
			end
			OP_PP_HI: begin
				mul_x = $signed(MUL_X_W'(div_q[CPS_W-1:PP_SPLIT]));
				mul_y = $signed({1'b0, cfg.rpm_scale});
			end
			OP_PP_LO: begin
				mul_x = $signed(MUL_X_W'(div_q[PP_SPLIT-1:0]));
				mul_y = $signed({1'b0, cfg.rpm_scale});
			end
			OP_FB: begin
				mul_x = $signed({{2{smoothed_q[ch_q][RPM_W-1]}}, smoothed_q[ch_q]});
				mul_y = $signed(MUL_Y_W'(cfg.feedback_coeff));
			end
			OP_IN: begin
				mul_x = MUL_X_W'(rpm_sum);
				mul_y = $signed(MUL_Y_W'(cfg.input_coeff));
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign prod = MUL_P_W'(mul_x) * MUL_P_W'(mul_y);

	// Raw rpm: truncate Q.24 to Q16.16, then clip by sign.
	assign prod_q8 = acc_q[ACC_W-1:8];
	always_comb begin
		if (neg_q) begin
			raw_over = (prod_q8 > (ACC_W-8)'(64'h8000_0000));
			raw_clip = raw_over ? 32'h8000_0000 : (RPM_W'(0) - acc_q[RPM_W+7:8]);
		end else begin
			raw_over = (prod_q8 > (ACC_W-8)'(64'h7FFF_FFFF));
			raw_clip = raw_over ? 32'h7FFF_FFFF : acc_q[RPM_W+7:8];
		end
	end

	// Filter output: arithmetic shift by 16, clip to 32 bits.
	assign filt_ok = (acc_q[ACC_W-1:RPM_W+15] == '0) || (acc_q[ACC_W-1:RPM_W+15] == '1);
	assign filt = filt_ok ? acc_q[RPM_W+15:16]
		: (acc_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	always_comb begin
		status.terr     = terr_q;
		status.cps_zero = (div_q == '0) || (cfg.rpm_scale == '0);
		status.cps_big  = |div_q[DIV_STEPS-1:CPS_W];
		status.out_busy = result_valid_q && result_stall;
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				idx_q   <= sample.motor_index;
				ch_q    <= ch_in;
				count_q <= sample.enc_count;
				el_q    <= sample.elapsed_us;
				terr_q  <= (sample.elapsed_us == '0);
				sat_q   <= 1'b0;
			end
			OP_DELTA: begin
				neg_q <= delta[CNT_W-1];
				mag_q <= delta[CNT_W-1] ? (CNT_W'(0) - delta) : delta;
			end
			OP_MULK: begin
				div_q <= prod[DIV_STEPS-1:0];
				rem_q <= '0;
			end
			OP_DIV: begin
				div_q <= {div_q[DIV_STEPS-2:0], ge};
				rem_q <= rem_d;
			end
			OP_PP_HI: acc_q <= {prod[PP_W-1:0], PP_SPLIT'(0)};
			OP_PP_LO: acc_q <= acc_q + ACC_W'(prod[PP_W-1:0]);
			OP_RAW_CLIP: begin
				raw_q <= raw_clip;
				sat_q <= raw_over;
			end
			OP_RAW_ZERO: raw_q <= '0;
			OP_RAW_SAT: begin
				raw_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
				sat_q <= 1'b1;
			end
			OP_FB: acc_q <= ACC_W'(prod);
			OP_IN: acc_q <= acc_q + ACC_W'(prod);
			OP_FILT: begin
				result_q.motor_id   <= idx_q;
				result_q.raw_rpm    <= raw_q;
				result_q.smooth_rpm <= filt;
				result_q.saturated  <= sat_q | !filt_ok;
				result_q.time_error <= terr_q;
			end
			default: ;
		endcase
	end

	// Per-motor history and the result beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTORS; m++) begin
				prior_count_q[m] <= '0;
				prior_rpm_q[m]   <= '0;
				smoothed_q[m]    <= '0;
			end
			result_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_DELTA) begin
				prior_count_q[ch_q] <= count_q;
			end
			if (ctrl.op == OP_FILT) begin
				prior_rpm_q[ch_q] <= raw_q;
				smoothed_q[ch_q]  <= filt;
				result_valid_q    <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

FILE: sv/encoder_speed_filter.sv
// Top level of the encoder speed filter: configuration registers, sequencer and datapath.
//
// Per-motor encoder speed estimator with first-order IIR smoothing. Each sample beat carries
// a motor index, that motor's raw 32-bit encoder count and the microseconds since its previous
// sample; each produces exactly one result beat with the raw rpm and filtered rpm (both signed
// Q16.16, saturated), a saturation flag and a zero-time flag. The count delta wraps modulo 2^32,
// is turned into whole counts per second (truncated toward zero), scaled by rpm_scale and fed
// to filtered = (feedback_coeff * filtered_old + input_coeff * (raw + raw_old)) >> 16. History
// for every motor resets to zero. One sample is in flight at a time; before its result is
// written it waits for the previous result beat to leave the output register. The restoring
// divider retires one quotient bit per cycle over 51 steps, followed by a short run of multiply
// steps on one shared multiplier. A new sample is taken while an earlier result still waits
// downstream. Write the configuration only while the block is idle.
module encoder_speed_filter import esf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data
);

	cfg_t        cfg_q;
	esf_ctrl_t   ctrl;
	esf_status_t status;
	logic        idle;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_scale      <= RPM_SCALE_RST;
			cfg_q.feedback_coeff <= FEEDBACK_COEFF_RST;
			cfg_q.input_coeff    <= INPUT_COEFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e_t'(cfg_index))
				REG_RPM_SCALE:      cfg_q.rpm_scale      <= cfg_data;
				REG_FEEDBACK_COEFF: cfg_q.feedback_coeff <= cfg_data[COEFF_W-1:0];
				REG_INPUT_COEFF:    cfg_q.input_coeff    <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept a sample beat only while the program sits at its idle step.
	assign sample_stall = !idle;

	esf_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.status       (status),
		.ctrl         (ctrl),
		.idle         (idle)
	);

	esf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sample       (sample),
		.cfg          (cfg_q),
		.result_stall (result_stall),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

FILE: tb/esf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the encoder speed filter: tracks settings, predicts each result beat, compares.
module esf_checker import esf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  sample_t              sample,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam longint          RPM_MAX    = 64'sd2147483647;
	localparam longint          RPM_MIN    = -64'sd2147483648;
	localparam longint unsigned CPS_CEIL   = 64'h0000_0100_0000_0000;
	localparam longint unsigned US_PER_SEC = 64'd1000000;

	logic [CNT_W-1:0]   hist_count  [MOTORS];
	logic [RPM_W-1:0]   last_raw    [MOTORS];
	logic [RPM_W-1:0]   last_smooth [MOTORS];
	logic [SCALE_W-1:0] scale_cfg;
	logic [COEFF_W-1:0] fb_cfg;
	logic [COEFF_W-1:0] in_cfg;
	result_t            expected_rpm [$];
	int                 mismatches;

	// Speed estimate and IIR step for one sample; advances that motor's history.
	function automatic result_t speed_estimate(input sample_t s);
		result_t         r;
		int              ch;
		logic [CNT_W-1:0] diff;
		int              d32;
		int              old_raw;
		int              old_smooth;
		longint          delta;
		longint          raw;
		longint          acc;
		longint          filt;
		longint unsigned mag;
		longint unsigned cps;
		longint unsigned prod;
		logic            neg;
		logic            sat;
		logic            terr;
		ch = int'(s.motor_index) % MOTORS;
		diff = s.enc_count - hist_count[ch];
		d32 = diff;
		delta = d32;
		hist_count[ch] = s.enc_count;
		sat = 1'b0;
		terr = 1'b0;
		raw = 0;
		if (s.elapsed_us == '0) begin
			terr = 1'b1;
		end else begin
			neg = delta < 0;
			mag = neg ? -delta : delta;
			cps = mag * US_PER_SEC / s.elapsed_us;
			if (cps == 0 || scale_cfg == '0) begin
				raw = 0;
			end else if (cps >= CPS_CEIL) begin
				sat = 1'b1;
				raw = neg ? RPM_MIN : RPM_MAX;
			end else begin
				prod = (cps * scale_cfg) >> 8;
				if (neg) begin
					if (prod > 64'd2147483648) begin
						sat = 1'b1;
						prod = 64'd2147483648;
					end
					raw = -longint'(prod);
				end else begin
					if (prod > 64'd2147483647) begin
						sat = 1'b1;
						prod = 64'd2147483647;
					end
					raw = longint'(prod);
				end
			end
		end
		old_raw = last_raw[ch];
		old_smooth = last_smooth[ch];
		acc = longint'(fb_cfg) * longint'(old_smooth)
			+ longint'(in_cfg) * (raw + longint'(old_raw));
		// arithmetic shift floors, as the filter requires
		filt = acc >>> 16;
		if (filt > RPM_MAX) begin
			sat = 1'b1;
			filt = RPM_MAX;
		end else if (filt < RPM_MIN) begin
			sat = 1'b1;
			filt = RPM_MIN;
		end
		last_raw[ch] = raw[RPM_W-1:0];
		last_smooth[ch] = filt[RPM_W-1:0];
		r.motor_id = s.motor_index;
		r.raw_rpm = raw[RPM_W-1:0];
		r.smooth_rpm = filt[RPM_W-1:0];
		r.saturated = sat;
		r.time_error = terr;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic    bad;
		if (!arst_n) begin
			for (int m = 0; m < MOTORS; m++) begin
				hist_count[m] = '0;
				last_raw[m] = '0;
				last_smooth[m] = '0;
			end
			scale_cfg = RPM_SCALE_RST;
			fb_cfg = FEEDBACK_COEFF_RST;
			in_cfg = INPUT_COEFF_RST;
			expected_rpm.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_e_t'(cfg_index))
					REG_RPM_SCALE: begin
						scale_cfg = cfg_data;
					end
					REG_FEEDBACK_COEFF: begin
						fb_cfg = cfg_data[COEFF_W-1:0];
					end
					REG_INPUT_COEFF: begin
						in_cfg = cfg_data[COEFF_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (sample_valid && !sample_stall)
				expected_rpm.push_back(speed_estimate(sample));
			if (result_valid && !result_stall) begin
				if (expected_rpm.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result beat ", $realtime,
							"id=%0d raw=%0d filt=%0d ", result.motor_id,
							result.raw_rpm, result.smooth_rpm,
							"sat=%0d terr=%0d", result.saturated, result.time_error);
				end else begin
					want = expected_rpm.pop_front();
					bad = (result.motor_id !== want.motor_id)
						|| (result.raw_rpm !== want.raw_rpm)
						|| (result.smooth_rpm !== want.smooth_rpm)
						|| (result.saturated !== want.saturated)
						|| (result.time_error !== want.time_error);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch ", $realtime,
								"exp id=%0d raw=%0d filt=%0d ", want.motor_id,
								want.raw_rpm, want.smooth_rpm,
								"sat=%0d terr=%0d | ", want.saturated, want.time_error,
								"got id=%0d raw=%0d filt=%0d ", result.motor_id,
								result.raw_rpm, result.smooth_rpm,
								"sat=%0d terr=%0d", result.saturated, result.time_error);
					end
				end
			end
			fail_count <= mismatches;
			pending <= expected_rpm.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the encoder speed filter testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
	import esf_pkg::*;

	// The longest receiver hold-off, and how long the run may sit with no beat moving.
	localparam int HOLD_CYCLES   = 700;
	localparam int QUIET_LIMIT   = 6000;
	localparam int SETTLE_CYCLES = 100;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_stall;
	sample_t              sample;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCALE_W-1:0]   cfg_data;
	int                   fail_count;
	int                   pending;

	// Raised once by the stimulus to ask the receiver for its long hold-off.
	logic hold_now = 1'b0;
	int   quiet_cycles = 0;

	// Stimulus-side view of each motor: last count sent and the speed it cruises at.
	logic [CNT_W-1:0] last_cnt [MOTORS];
	int               cruise   [MOTORS];

	encoder_speed_filter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	esf_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length between beats: mostly none, often a few cycles, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one sample beat, hold it until taken, then idle for a while if gaps are on.
	task automatic send_sample(input logic m, input logic [CNT_W-1:0] c,
			input logic [EL_W-1:0] e, input bit gaps);
		int idle;
		sample <= '{motor_index: m, enc_count: c, elapsed_us: e};
		sample_valid <= 1'b1;
		last_cnt[m] = c;
		do @(posedge clk); while (sample_stall);
		idle = gaps ? gap_len() : 0;
		if (idle > 0) begin
			sample_valid <= 1'b0;
			idle = idle;
			repeat (idle) @(posedge clk);
		end
	endtask

	// Mostly motors cruising at a steady speed with jitter, the rest noise and odd timing.
	task automatic run_random(input int n, input bit gaps);
		logic             m;
		int               r;
		logic [EL_W-1:0]  el;
		logic [CNT_W-1:0] c;
		for (int i = 0; i < n; i++) begin
			m = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				cruise[m] = int'($urandom_range(0, 600)) - 300;
			el = EL_W'($urandom_range(500, 1500));
			c = last_cnt[m] + cruise[m] + int'($urandom_range(0, 10)) - 5;
			if (r < 8) begin
				// jump the count anywhere
				c = $urandom;
			end else if (r < 13) begin
				el = '0;
			end else if (r < 18) begin
				el = ($urandom_range(0, 1) == 0) ? EL_W'(1) : '1;
			end else if (r < 24) begin
				el = EL_W'($urandom);
			end else if (r < 28) begin
				c = last_cnt[m];
			end else if (r < 34) begin
				c = last_cnt[m] + int'($urandom_range(0, 2000000)) - 1000000;
			end
			send_sample(m, c, el, gaps);
		end
	endtask

	// Drain the block, then write all three registers in one burst of beats.
	task automatic load_settings(input logic [SCALE_W-1:0] scale,
			input logic [COEFF_W-1:0] fb, input logic [COEFF_W-1:0] ic);
		cfg_reg_e_t         which [3];
		logic [SCALE_W-1:0] value [3];
		which[0] = REG_RPM_SCALE;
		which[1] = REG_FEEDBACK_COEFF;
		which[2] = REG_INPUT_COEFF;
		value[0] = scale;
		value[1] = SCALE_W'(fb);
		value[2] = SCALE_W'(ic);
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= which[i];
			cfg_data <= value[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stall runs, free-flowing stretches, and one long hold-off on request.
	initial begin
		bit held;
		int n;
		held = 1'b0;
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_now && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = gap_len();
				if (n == 0) begin
					result_stall <= 1'b0;
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 30);
				end else begin
					result_stall <= 1'b1;
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no beat of any channel has moved for too long.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		logic [COEFF_W-1:0] fb;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RPM_SCALE;
		cfg_data <= '0;
		for (int m = 0; m < MOTORS; m++) begin
			last_cnt[m] = '0;
			cruise[m] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset settings: corners of count and elapsed time.
		send_sample(1'b0, 32'h0000_0000, 16'd0, 1'b1);    // zero elapsed time
		send_sample(1'b0, 32'd1000, 16'd1000, 1'b1);      // forward
		send_sample(1'b0, 32'd500, 16'd1000, 1'b1);       // reverse
		send_sample(1'b0, 32'd500, 16'd1000, 1'b1);       // standstill
		send_sample(1'b0, 32'h7FFF_FFFF, 16'd1, 1'b1);    // huge forward speed
		send_sample(1'b0, 32'h8000_0000, 16'd1, 1'b1);    // count wraps, delta of one
		send_sample(1'b0, 32'h7FFF_FFFF, 16'hFFFF, 1'b1); // one back over the longest time
		send_sample(1'b0, 32'hFFFF_FFFF, 16'd1, 1'b1);    // most negative delta
		send_sample(1'b1, 32'd12345, 16'hFFFF, 1'b1);
		send_sample(1'b1, 32'hFFFF_CFC7, 16'd1, 1'b1);    // large reverse speed
		send_sample(1'b1, 32'hFFFF_CFC7, 16'd0, 1'b1);    // zero time on a standstill
		send_sample(1'b1, 32'h5555_5555, 16'hAAAA, 1'b1);
		send_sample(1'b1, 32'hAAAA_AAAA, 16'h5555, 1'b1);
		send_sample(1'b0, 32'h0000_0000, 16'hFFFF, 1'b1);
		send_sample(1'b0, 32'h0000_0001, 16'hFFFF, 1'b1); // slowest nonzero speed
		send_sample(1'b0, 32'h0000_0001, 16'd0, 1'b1);

		// Reset values written back explicitly; the receiver holds off early in this phase.
		load_settings(RPM_SCALE_RST, FEEDBACK_COEFF_RST, INPUT_COEFF_RST);
		hold_now <= 1'b1;
		run_random(150, 1'b1);

		// Full-scale settings: drive both motors into raw and filter saturation.
		load_settings('1, '1, '1);
		for (int k = 0; k < 4; k++) begin
			send_sample(1'b0, last_cnt[0] + 32'd1000, 16'd1, 1'b1);
			send_sample(1'b1, last_cnt[1] - 32'd1000, 16'd1, 1'b1);
		end
		run_random(70, 1'b1);

		// Everything zero, sent back to back.
		load_settings('0, '0, '0);
		run_random(40, 1'b0);

		load_settings(SCALE_W'(1), '0, '1);
		run_random(50, 1'b1);

		// Random settings, the last one a well-behaved filter with unity gain.
		repeat (2) begin
			load_settings(SCALE_W'($urandom), COEFF_W'($urandom), COEFF_W'($urandom));
			run_random(70, 1'b1);
		end
		fb = COEFF_W'($urandom_range(0, 65535));
		load_settings(SCALE_W'($urandom), fb, COEFF_W'((17'h10000 - fb) >> 1));
		run_random(70, 1'b1);

		// Drain, let the block settle, then give the verdict.
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("%0d expected result beats never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: files.f
sv/esf_pkg.sv
sv/esf_seq.sv
sv/esf_dp.sv
sv/encoder_speed_filter.sv
tb/esf_checker.sv
tb/testbench.sv
